// ===== hw/rtl/lvas_pkg.sv =====
// Shared types, codes and constants of the local variance adaptive smoothing block.
package lvas_pkg;

    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 4;
    localparam int CH_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GEO_W      = 11;
    localparam int SIGMA_W    = 16;
    localparam int MAX_HEIGHT = 1024;
    localparam int HGT_W      = 11;
    localparam int ROW_W      = 10;
    localparam int K_W        = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA        = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [GEO_W-1:0]   WIDTH_RESET  = 11'd640;
    localparam logic [GEO_W-1:0]   HEIGHT_RESET = 11'd480;
    localparam logic [SIGMA_W-1:0] SIGMA_RESET  = 16'd289;

    typedef struct packed {
        logic             command;
        logic [PIX_W-1:0] in_ch0;
        logic [PIX_W-1:0] in_ch1;
        logic [PIX_W-1:0] in_ch2;
        logic [PIX_W-1:0] in_ch3;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] out_ch0;
        logic [PIX_W-1:0] out_ch1;
        logic [PIX_W-1:0] out_ch2;
        logic [PIX_W-1:0] out_ch3;
        logic             frame_last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_SWEEP,
        S_DRAIN,
        S_MUL,
        S_SUB,
        S_KLOAD,
        S_KRUN,
        S_MLOAD,
        S_MIXMUL,
        S_MIXADD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic take;
        logic setup_step;
        logic sweep;
        logic mul;
        logic sub;
        logic kload;
        logic div_step;
        logic mload;
        logic mixmul;
        logic mixadd;
        logic out_done;
    } t_dp_cmd;

    typedef struct packed {
        logic emit;
        logic setup_last;
        logic sweep_last;
        logic div_last;
        logic ch_last;
    } t_dp_sts;

endpackage

// ===== hw/rtl/lvas_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module lvas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lvas_ctrl.sv =====
// Controller state machine sequencing window sweep, gain and blend per output pixel.
module lvas_ctrl
    import lvas_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.emit) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup_step = 1'b1;
                if (i_sts.setup_last) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_KLOAD;
            end
            S_KLOAD: begin
                o_cmd.kload = 1'b1;
                n_state     = S_KRUN;
            end
            S_KRUN: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MLOAD;
                end
            end
            S_MLOAD: begin
                o_cmd.mload = 1'b1;
                n_state     = S_MIXMUL;
            end
            S_MIXMUL: begin
                o_cmd.mixmul = 1'b1;
                n_state      = S_MIXADD;
            end
            S_MIXADD: begin
                o_cmd.mixadd = 1'b1;
                n_state      = i_sts.ch_last ? S_OUT : S_MUL;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.out_done = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lvas_datapath.sv =====
// Datapath: line store, position tracking, window accumulation, divider and blend.
module lvas_datapath
    import lvas_pkg::*;
#(
    parameter int KERNEL_SIZE = 17,
    parameter int MAX_WIDTH   = 1024,
    parameter int CHANNELS    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_item              i_in_data,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts
);

    localparam int RADIUS  = KERNEL_SIZE / 2;
    localparam int SPAN    = 2 * RADIUS + 1;
    localparam int SLOTS   = SPAN + 1;
    localparam int AREA    = KERNEL_SIZE * KERNEL_SIZE;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WID_W   = $clog2(MAX_WIDTH + 1);
    localparam int POS_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int LEN_W   = (WID_W > HGT_W) ? WID_W : HGT_W;
    localparam int DEPTH   = SLOTS * MAX_WIDTH;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int WIN_W   = $clog2(SPAN);
    localparam int S_W     = $clog2(SPAN * SPAN * 255 + 1);
    localparam int Q_W     = $clog2(SPAN * SPAN * 65025 + 1);
    localparam longint V_MAX      = longint'(AREA) * longint'(SPAN * SPAN) * 65025;
    localparam longint AREA2      = longint'(AREA) * longint'(AREA);
    localparam longint SPREAD_MAX = 65535 * AREA2;
    localparam int V_W     = $clog2(V_MAX + 1);
    localparam int D_W     = $clog2(V_MAX + SPREAD_MAX + 1);
    localparam int P_W     = (V_W > 2 * S_W) ? V_W : 2 * S_W;
    localparam int NUM_W   = V_W + 16;
    localparam int DCNT_W  = $clog2(NUM_W);
    localparam int MIX_W   = K_W + S_W + 1;

    // Reciprocal of the area, exact for every window sum of S_W bits
    localparam int     MEAN_SH  = S_W + $clog2(AREA);
    localparam longint MEAN_M   = ((longint'(1) << MEAN_SH) + longint'(AREA) - 1) /
                                  longint'(AREA);
    localparam int     MEAN_M_W = $clog2(MEAN_M + 1);
    localparam int     MPROD_W  = S_W + MEAN_M_W;

    localparam logic [ADDR_W-1:0] MAXW_C   = ADDR_W'(MAX_WIDTH);
    localparam logic [K_W-1:0]     ONE_K    = K_W'(65536);

    // Configuration registers
    logic [GEO_W-1:0]   r_width;
    logic [GEO_W-1:0]   r_height;
    logic [SIGMA_W-1:0] r_sigma;

    // Input and output raster positions
    logic [COL_W-1:0]  r_in_col;
    logic [HGT_W-1:0]  r_in_row;
    logic [SLOT_W-1:0] r_in_slot;
    logic [CNT_W-1:0]  r_in_n;
    logic              r_frame_done;
    logic [CNT_W-1:0]  r_out_idx;
    logic [COL_W-1:0]  r_out_col;
    logic [POS_W-1:0]  r_out_row;
    logic [SLOT_W-1:0] r_out_slot;

    // Window walkers
    logic [POS_W-1:0]  r_rv;
    logic              r_rdir;
    logic [SLOT_W-1:0] r_rslot;
    logic [POS_W-1:0]  r_cv;
    logic              r_cdir;
    logic [POS_W-1:0]  r_cstart;
    logic              r_cstart_dir;
    logic [WIN_W-1:0]  r_dx;
    logic [WIN_W-1:0]  r_dy;
    logic              r_rd_vld;
    logic              r_rd_ctr;

    // Accumulators and arithmetic
    logic [S_W-1:0]          r_s [NUM_CH];
    logic [Q_W-1:0]          r_q [NUM_CH];
    logic [NUM_CH*PIX_W-1:0] r_center;
    logic [CH_W-1:0]         r_ch;
    logic [P_W-1:0]          r_p1;
    logic [P_W-1:0]          r_p2;
    logic [D_W-1:0]          r_p3;
    logic [V_W-1:0]          r_v;
    logic [NUM_W-1:0]        r_num;
    logic [D_W-1:0]          r_den;
    logic [D_W-1:0]          r_rem;
    logic [NUM_W-1:0]        r_quo;
    logic [DCNT_W-1:0]       r_dcnt;
    logic [K_W-1:0]          r_k;
    logic [S_W-1:0]          r_mean;
    logic [MIX_W-1:0]        r_m1;
    logic [MIX_W-1:0]        r_m2;
    logic [PIX_W-1:0]        r_res [NUM_CH];

    logic [NUM_CH*PIX_W-1:0] rdata;
    logic [WID_W-1:0]        eff_w;
    logic [HGT_W-1:0]        eff_h;
    logic [CNT_W-1:0]        total;
    logic [CNT_W-1:0]        lag;
    logic                    pix_take;
    logic [COL_W-1:0]        cur_col;
    logic [HGT_W-1:0]        cur_row;
    logic [SLOT_W-1:0]       cur_slot;
    logic [CNT_W-1:0]        cur_n;
    logic                    geo_write;
    logic [ADDR_W-1:0]       waddr;
    logic [ADDR_W-1:0]       raddr;
    logic [POS_W:0]          rstep_b;
    logic [POS_W:0]          cstep_b;
    logic [POS_W:0]          rstep_f;
    logic [POS_W:0]          cstep_f;
    logic [S_W-1:0]          sel_s;
    logic [Q_W-1:0]          sel_q;
    logic [PIX_W-1:0]        sel_pix;
    logic [D_W:0]            div_shift;
    logic                    div_bit;
    logic [MIX_W-1:0]        mix_sum;
    logic [MPROD_W-1:0]      mean_prod;

    // One step of a reflect-101 walk; returns {direction of motion, new index}
    function automatic logic [POS_W:0] wstep(input logic [POS_W-1:0] v, input logic up,
                                             input logic [LEN_W-1:0] len);
        logic [POS_W-1:0] nv;
        logic             nd;
        logic [LEN_W-1:0] lastp;
        lastp = len - LEN_W'(1);
        nv    = v;
        nd    = up;
        if (len > LEN_W'(1)) begin
            if (up) begin
                if (LEN_W'(v) == lastp) begin
                    nv = v - POS_W'(1);
                    nd = 1'b0;
                end else begin
                    nv = v + POS_W'(1);
                end
            end else begin
                if (v == '0) begin
                    nv = POS_W'(1);
                    nd = 1'b1;
                end else begin
                    nv = v - POS_W'(1);
                end
            end
        end
        return {nd, nv};
    endfunction

    function automatic logic [SLOT_W-1:0] slot_move(input logic [SLOT_W-1:0] s, input logic up);
        logic [SLOT_W-1:0] r;
        if (up) begin
            r = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
        end else begin
            r = (s == '0) ? SLOT_W'(SLOTS - 1) : s - SLOT_W'(1);
        end
        return r;
    endfunction

    // Clamp geometry and derive frame totals
    always_comb begin
        if (r_width == '0) begin
            eff_w = WID_W'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(r_width);
        end
        if (r_height == '0) begin
            eff_h = HGT_W'(1);
        end else if (int'(r_height) > MAX_HEIGHT) begin
            eff_h = HGT_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_height;
        end
    end

    assign total = CNT_W'(CNT_W'(eff_w) * CNT_W'(eff_h));
    assign lag   = CNT_W'(CNT_W'(RADIUS) * CNT_W'(eff_w)) + CNT_W'(RADIUS);

    // Restart positions when a pixel opens a new frame
    assign pix_take  = i_cmd.take && (i_in_data.command == CMD_PIXEL);
    assign cur_col   = r_frame_done ? '0 : r_in_col;
    assign cur_row   = r_frame_done ? '0 : r_in_row;
    assign cur_slot  = r_frame_done ? '0 : r_in_slot;
    assign cur_n     = r_frame_done ? '0 : r_in_n;
    assign geo_write = i_cfg_we && ((i_cfg_index == CFG_IMAGE_WIDTH) ||
                                    (i_cfg_index == CFG_IMAGE_HEIGHT));

    assign waddr = ADDR_W'(cur_slot) * MAXW_C + ADDR_W'(cur_col);
    assign raddr = ADDR_W'(r_rslot) * MAXW_C + ADDR_W'(r_cv);

    lvas_ram #(
        .WIDTH (NUM_CH * PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (pix_take),
        .i_waddr (waddr),
        .i_wdata ({i_in_data.in_ch3, i_in_data.in_ch2, i_in_data.in_ch1, i_in_data.in_ch0}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Walker steps: backward during setup, forward during the sweep
    assign rstep_b = wstep(r_rv, !r_rdir, LEN_W'(eff_h));
    assign cstep_b = wstep(r_cv, !r_cdir, LEN_W'(eff_w));
    assign rstep_f = wstep(r_rv, r_rdir, LEN_W'(eff_h));
    assign cstep_f = wstep(r_cv, r_cdir, LEN_W'(eff_w));

    // Status to the controller
    always_comb begin
        if (i_in_data.command == CMD_PIXEL) begin
            o_sts.emit = !r_frame_done && (r_in_n >= lag) && (r_out_idx < total);
        end else begin
            o_sts.emit = r_frame_done && (r_out_idx < total);
        end
        o_sts.setup_last = (r_dx == WIN_W'(RADIUS - 1));
        o_sts.sweep_last = (r_dx == WIN_W'(SPAN - 1)) && (r_dy == WIN_W'(SPAN - 1));
        o_sts.div_last   = (r_dcnt == DCNT_W'(NUM_W - 1));
        o_sts.ch_last    = (r_ch == CH_W'(NUM_CH - 1));
    end

    // Control state: configuration and raster positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= WIDTH_RESET;
            r_height     <= HEIGHT_RESET;
            r_sigma      <= SIGMA_RESET;
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_in_slot    <= '0;
            r_in_n       <= '0;
            r_frame_done <= 1'b0;
            r_out_idx    <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_out_slot   <= '0;
            r_rd_vld     <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.sweep;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[GEO_W-1:0];
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[GEO_W-1:0];
                    CFG_SIGMA:        r_sigma  <= i_cfg_data[SIGMA_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (geo_write) begin
                r_in_col     <= '0;
                r_in_row     <= '0;
                r_in_slot    <= '0;
                r_in_n       <= '0;
                r_frame_done <= 1'b0;
                r_out_idx    <= '0;
                r_out_col    <= '0;
                r_out_row    <= '0;
                r_out_slot   <= '0;
            end else if (pix_take) begin
                // Advance the input position, wrapping at the row end
                r_in_n <= cur_n + CNT_W'(1);
                if ((WID_W'(cur_col) + WID_W'(1)) >= eff_w) begin
                    r_in_col     <= '0;
                    r_in_row     <= cur_row + HGT_W'(1);
                    r_in_slot    <= slot_move(cur_slot, 1'b1);
                    r_frame_done <= (cur_row + HGT_W'(1)) >= eff_h;
                end else begin
                    r_in_col     <= cur_col + COL_W'(1);
                    r_in_row     <= cur_row;
                    r_in_slot    <= cur_slot;
                    r_frame_done <= 1'b0;
                end
                if (r_frame_done) begin
                    r_out_idx  <= '0;
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                    r_out_slot <= '0;
                end
            end else if (i_cmd.out_done) begin
                // Advance the output position
                r_out_idx <= r_out_idx + CNT_W'(1);
                if ((WID_W'(r_out_col) + WID_W'(1)) >= eff_w) begin
                    r_out_col  <= '0;
                    r_out_row  <= r_out_row + POS_W'(1);
                    r_out_slot <= slot_move(r_out_slot, 1'b1);
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
            end
        end
    end

    // Window walk, accumulation and per-channel arithmetic
    always_ff @(posedge i_clk) begin
        r_rd_ctr <= i_cmd.sweep && (r_dx == WIN_W'(RADIUS)) && (r_dy == WIN_W'(RADIUS));
        if (i_cmd.take) begin
            r_rv    <= r_out_row;
            r_rdir  <= 1'b1;
            r_rslot <= r_out_slot;
            r_cv    <= POS_W'(r_out_col);
            r_cdir  <= 1'b1;
            r_dx    <= '0;
            r_dy    <= '0;
            r_ch    <= '0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_s[c] <= '0;
                r_q[c] <= '0;
            end
        end
        if (i_cmd.setup_step) begin
            r_rv    <= rstep_b[POS_W-1:0];
            r_rdir  <= !rstep_b[POS_W];
            r_cv    <= cstep_b[POS_W-1:0];
            r_cdir  <= !cstep_b[POS_W];
            if (eff_h > HGT_W'(1)) begin
                r_rslot <= slot_move(r_rslot, rstep_b[POS_W]);
            end
            if (o_sts.setup_last) begin
                r_dx         <= '0;
                r_cstart     <= cstep_b[POS_W-1:0];
                r_cstart_dir <= !cstep_b[POS_W];
            end else begin
                r_dx <= r_dx + WIN_W'(1);
            end
        end
        if (i_cmd.sweep) begin
            if (r_dx == WIN_W'(SPAN - 1)) begin
                r_dx   <= '0;
                r_dy   <= r_dy + WIN_W'(1);
                r_cv   <= r_cstart;
                r_cdir <= r_cstart_dir;
                r_rv   <= rstep_f[POS_W-1:0];
                r_rdir <= rstep_f[POS_W];
                if (eff_h > HGT_W'(1)) begin
                    r_rslot <= slot_move(r_rslot, rstep_f[POS_W]);
                end
            end else begin
                r_dx   <= r_dx + WIN_W'(1);
                r_cv   <= cstep_f[POS_W-1:0];
                r_cdir <= cstep_f[POS_W];
            end
        end
        // Accumulate the sample whose read was issued in the previous cycle
        if (r_rd_vld) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_s[c] <= r_s[c] + S_W'(rdata[c*PIX_W +: PIX_W]);
                r_q[c] <= r_q[c] + Q_W'({8'd0, rdata[c*PIX_W +: PIX_W]} *
                                        {8'd0, rdata[c*PIX_W +: PIX_W]});
            end
        end
        if (r_rd_ctr) begin
            r_center <= rdata;
        end
        if (i_cmd.mul) begin
            r_p1 <= P_W'(P_W'(AREA) * P_W'(sel_q));
            r_p2 <= P_W'(sel_s) * P_W'(sel_s);
            r_p3 <= D_W'(D_W'(r_sigma) * D_W'(AREA2));
        end
        if (i_cmd.sub) begin
            r_v <= (r_p1 >= r_p2) ? V_W'(r_p1 - r_p2) : '0;
        end
        // Gain division: (V << 16) / (V + spread)
        if (i_cmd.kload) begin
            r_num  <= {r_v, 16'd0};
            r_den  <= D_W'(r_v) + r_p3;
            r_rem  <= '0;
            r_quo  <= '0;
            r_dcnt <= '0;
        end
        // Latch the gain and the mean S / area by reciprocal multiplication
        if (i_cmd.mload) begin
            r_k    <= (r_den == '0) ? '0 : r_quo[K_W-1:0];
            r_mean <= S_W'(mean_prod >> MEAN_SH);
        end
        if (i_cmd.div_step) begin
            r_rem  <= div_bit ? D_W'(div_shift - {1'b0, r_den}) : div_shift[D_W-1:0];
            r_quo  <= {r_quo[NUM_W-2:0], div_bit};
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
        if (i_cmd.mixmul) begin
            r_m1 <= MIX_W'(ONE_K - r_k) * MIX_W'(r_mean);
            r_m2 <= MIX_W'(r_k) * MIX_W'(sel_pix);
        end
        if (i_cmd.mixadd) begin
            r_res[r_ch] <= (int'(r_ch) < CHANNELS) ? mix_sum[16 +: PIX_W] : sel_pix;
            r_ch        <= r_ch + CH_W'(1);
        end
    end

    assign sel_s     = r_s[r_ch];
    assign sel_q     = r_q[r_ch];
    assign sel_pix   = r_center[r_ch*PIX_W +: PIX_W];
    assign div_shift = {r_rem, r_num[NUM_W-1]};
    assign div_bit   = (div_shift >= {1'b0, r_den});
    assign mix_sum   = r_m1 + r_m2;
    assign mean_prod = MPROD_W'(sel_s) * MPROD_W'(MEAN_M);

    // Result item
    always_comb begin
        o_out_data.out_ch0    = r_res[0];
        o_out_data.out_ch1    = r_res[1];
        o_out_data.out_ch2    = r_res[2];
        o_out_data.out_ch3    = r_res[3];
        o_out_data.frame_last = (r_out_idx == (total - CNT_W'(1)));
    end

endmodule

// ===== hw/rtl/local_variance_adaptive_smoothing.sv =====
// Top level of the local variance adaptive smoothing block.
// Lee-type local statistics filter on a four-channel raster stream. Pixels
// are written to a line store of 2*(KERNEL_SIZE/2)+2 rows; once a pixel
// RADIUS rows and RADIUS columns beyond an output position arrives, that
// output is computed, and flush transactions after the frame drain the rest.
// A transaction that produces no result is accepted in idle and starts no
// computation. The duration of a result transaction is set by the single
// line store read port, which delivers one window sample per cycle, and the
// shared bit-serial gain divider, which runs once per channel; the mean uses
// a reciprocal multiply. The line store needs no clearing after reset. Only
// one transaction is in flight; input ready is low from acceptance until the
// result is taken.
module local_variance_adaptive_smoothing
    import lvas_pkg::*;
#(
    parameter int KERNEL_SIZE = 17,
    parameter int MAX_WIDTH   = 1024,
    parameter int CHANNELS    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    lvas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    lvas_datapath #(
        .KERNEL_SIZE (KERNEL_SIZE),
        .MAX_WIDTH   (MAX_WIDTH),
        .CHANNELS    (CHANNELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// ===== hw/rtl/lvas_checker.sv =====
// Port-level checker for the smoothing block and its bind to the top level.
module lvas_checker
    import lvas_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // Block new input while a result waits
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while a result is pending");

    // Drop any result on reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A result only follows computation with input blocked
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without a computation phase");

endmodule

bind local_variance_adaptive_smoothing lvas_checker u_lvas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== bench/local_variance_adaptive_smoothing_tb.sv =====
// Testbench for the local variance adaptive smoothing block: random frames checked against a predictor.
`timescale 1ns / 100ps

module local_variance_adaptive_smoothing_tb;
    import lvas_pkg::*;

    localparam int KSZ      = 17;
    localparam int RAD      = KSZ / 2;
    localparam int ROWS_HELD = 2 * RAD + 2;
    localparam int MAXW     = 1024;
    localparam int SETTLE   = 1000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {PAT_RANDOM, PAT_FLAT, PAT_EXTREME, PAT_NOISY} t_pattern;

    // Predicts smoothed pixels and holds them until the block delivers them
    class lvas_scoreboard;
        bit [31:0]   pix_rows [ROWS_HELD*MAXW];
        int unsigned row_pos, col_pos, out_pos;
        bit          frame_in;
        bit [10:0]   width_reg, height_reg;
        bit [15:0]   sigma_reg;
        t_out_item   pending [$];
        int          errors;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            sigma_reg  = SIGMA_RESET;
            errors     = 0;
            restart();
        endfunction

        function int unsigned eff_w();
            if (width_reg == 0) return 1;
            if (width_reg > MAXW) return MAXW;
            return width_reg;
        endfunction

        function int unsigned eff_h();
            if (height_reg == 0) return 1;
            if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
            return height_reg;
        endfunction

        function void restart();
            row_pos  = 0;
            col_pos  = 0;
            out_pos  = 0;
            frame_in = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_IMAGE_WIDTH) begin
                width_reg = val[10:0];
                restart();
            end else if (idx == CFG_IMAGE_HEIGHT) begin
                height_reg = val[10:0];
                restart();
            end else if (idx == CFG_SIGMA) begin
                sigma_reg = val;
            end
        endfunction

        // Mirror an index into the frame without repeating the edge sample
        function int unsigned fold(int p, int len);
            if (len <= 1) return 0;
            while (p < 0 || p >= len) begin
                if (p < 0) p = -p;
                else p = 2 * len - 2 - p;
            end
            return p;
        endfunction

        function int unsigned owed();
            if (!frame_in) return 0;
            return eff_w() * eff_h() - out_pos;
        endfunction

        // Compute the next output pixel in raster order
        function void smooth_next();
            int unsigned      w, h, r, c, rr, cc;
            bit [31:0]        centre;
            longint unsigned  s, q, v, d, k, mean, x, pix, spread;
            bit [7:0]         res [4];
            t_out_item        item;
            w = eff_w();
            h = eff_h();
            r = out_pos / w;
            c = out_pos % w;
            centre = pix_rows[(r % ROWS_HELD) * MAXW + c];
            spread = longint'(sigma_reg) * KSZ * KSZ * KSZ * KSZ;
            for (int ch = 0; ch < 4; ch++) begin
                s = 0;
                q = 0;
                for (int dy = -RAD; dy <= RAD; dy++) begin
                    rr = fold(int'(r) + dy, h);
                    for (int dx = -RAD; dx <= RAD; dx++) begin
                        cc = fold(int'(c) + dx, w);
                        x = (pix_rows[(rr % ROWS_HELD) * MAXW + cc] >> (ch * 8)) & 8'hFF;
                        s += x;
                        q += x * x;
                    end
                end
                v = KSZ * KSZ * q;
                v = (v >= s * s) ? v - s * s : 0;
                d = v + spread;
                k = (d == 0) ? 0 : (v << 16) / d;
                mean = s / (KSZ * KSZ);
                pix = (centre >> (ch * 8)) & 8'hFF;
                res[ch] = 8'((((65536 - k) * mean) + k * pix) >> 16);
            end
            item.out_ch0    = res[0];
            item.out_ch1    = res[1];
            item.out_ch2    = res[2];
            item.out_ch3    = res[3];
            item.frame_last = (out_pos == w * h - 1);
            pending.push_back(item);
            out_pos++;
        endfunction

        function void note_input(t_in_item it);
            int unsigned w, h, n;
            w = eff_w();
            h = eff_h();
            if (it.command == CMD_PIXEL) begin
                if (frame_in) restart();
                pix_rows[(row_pos % ROWS_HELD) * MAXW + col_pos] =
                    {it.in_ch3, it.in_ch2, it.in_ch1, it.in_ch0};
                n = row_pos * w + col_pos;
                col_pos++;
                if (col_pos >= w) begin
                    col_pos = 0;
                    row_pos++;
                    if (row_pos >= h) frame_in = 1;
                end
                if (n >= RAD * w + RAD && out_pos < w * h) smooth_next();
            end else if (frame_in && out_pos < w * h) begin
                smooth_next();
            end
        endfunction

        function void report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected pixel %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.out_ch0 != want.out_ch0)
                report($sformatf("ch0 got %h want %h", got.out_ch0, want.out_ch0));
            if (got.out_ch1 != want.out_ch1)
                report($sformatf("ch1 got %h want %h", got.out_ch1, want.out_ch1));
            if (got.out_ch2 != want.out_ch2)
                report($sformatf("ch2 got %h want %h", got.out_ch2, want.out_ch2));
            if (got.out_ch3 != want.out_ch3)
                report($sformatf("ch3 got %h want %h", got.out_ch3, want.out_ch3));
            if (got.frame_last != want.frame_last)
                report($sformatf("frame_last got %b want %b", got.frame_last, want.frame_last));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lvas_scoreboard sb;
    bit             calm;
    bit             hold_req;
    int             sent;
    bit [7:0]       flat_val;

    local_variance_adaptive_smoothing u_dut (.*);

    // Clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Offer one transaction, idling at random beforehand
    task automatic send_item(t_in_item it);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 36) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
        sent++;
    endtask

    task automatic send_flush();
        t_in_item it;
        it         = t_in_item'({CMD_FLUSH, 32'($urandom)});
        it.command = CMD_FLUSH;
        send_item(it);
    endtask

    // Pick a pixel for the given pattern
    function automatic t_in_item make_pixel(t_pattern pat);
        t_in_item it;
        it = t_in_item'({CMD_PIXEL, 32'($urandom)});
        case (pat)
            PAT_FLAT: begin
                it = {CMD_PIXEL, flat_val, flat_val, flat_val, flat_val};
            end
            PAT_EXTREME: begin
                it.in_ch0 = $urandom_range(1) ? 8'hFF : 8'h00;
                it.in_ch1 = $urandom_range(1) ? 8'hFF : 8'h00;
                it.in_ch2 = $urandom_range(1) ? 8'hFF : 8'h00;
                it.in_ch3 = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            PAT_NOISY: begin
                it.in_ch0 = flat_val ^ 8'($urandom_range(3));
                it.in_ch1 = flat_val ^ 8'($urandom_range(3));
                it.in_ch2 = flat_val;
                it.in_ch3 = 8'($urandom_range(255));
            end
            default: ;
        endcase
        it.command = CMD_PIXEL;
        return it;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_in_valid  = 1'b0;
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.write_reg(idx, val);
    endtask

    // Wait until every expected pixel has arrived and the block is quiet
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_geometry(logic [15:0] w, logic [15:0] h, logic [15:0] sig);
        settle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_SIGMA, sig);
    endtask

    // Stream whole frames; drain fully after the last, partly between others
    task automatic run_frames(int nframes, t_pattern pat, bit early_flush);
        int unsigned total, extra;
        total = sb.eff_w() * sb.eff_h();
        for (int f = 0; f < nframes; f++) begin
            flat_val = 8'($urandom);
            for (int unsigned p = 0; p < total; p++) begin
                if (early_flush && p == total / 2) send_flush();
                send_item(make_pixel(pat));
            end
            extra = (f == nframes - 1) ? sb.owed() + $urandom_range(2)
                                       : $urandom_range(sb.owed());
            repeat (extra) send_flush();
        end
    endtask

    // Receiver: sample at the rising edge, decide ready at the falling edge
    initial begin
        int hold_left;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
            @(negedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_left = 3000;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = calm || $urandom_range(99) >= 36;
            end
        end
    end

    // Stimulus
    initial begin
        t_in_item it;
        int unsigned w, h;
        logic [15:0] sig;
        sb          = new();
        calm        = 1'b0;
        hold_req    = 1'b0;
        sent        = 0;
        flat_val    = 8'h00;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_IMAGE_WIDTH;
        i_cfg_data  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Flat frame with zero sigma: zero variance, zero gain denominator
        set_geometry(16'd3, 16'd3, 16'd0);
        run_frames(1, PAT_FLAT, 1'b1);
        // Zero width and height act as one pixel; strongest smoothing
        set_geometry(16'd0, 16'd0, 16'hFFFF);
        it = {CMD_PIXEL, 8'hFF, 8'h00, 8'hFF, 8'h00};
        send_item(it);
        send_flush();
        send_flush();
        it = {CMD_PIXEL, 8'h00, 8'hFF, 8'h00, 8'hFF};
        send_item(it);
        send_flush();
        // Oversized width acts as the maximum; partial frame is dropped
        set_geometry(16'hFFFF, 16'd2, 16'd1);
        repeat (5) send_item(make_pixel(PAT_EXTREME));
        // Oversized height on a one-wide column; unused index does nothing
        set_geometry(16'd1, 16'hFFFF, 16'd289);
        write_reg(CFG_UNUSED, 16'hFFFF);
        repeat (20) send_item(make_pixel(PAT_RANDOM));

        // Random frames, mostly small; pixels during drain start a new frame
        for (int ph = 0; sent < 1500; ph++) begin
            calm = (ph >= 6 && ph < 10);
            if ($urandom_range(9) == 0) begin
                w = $urandom_range(40, 13);
                h = $urandom_range(3, 1);
            end else begin
                w = $urandom_range(10, 1);
                h = $urandom_range(10, 1);
            end
            case ($urandom_range(3))
                0: sig = 16'd0;
                1: sig = 16'hFFFF;
                2: sig = 16'($urandom_range(400));
                default: sig = 16'($urandom);
            endcase
            set_geometry(16'(w), 16'(h), sig);
            if (ph == 3) hold_req = 1'b1;
            if ($urandom_range(9) == 0) begin
                // Abandon a frame midway by rewriting geometry
                repeat ($urandom_range(w * h)) send_item(make_pixel(PAT_RANDOM));
            end else begin
                run_frames($urandom_range(2, 1), t_pattern'($urandom_range(3)),
                           $urandom_range(3) == 0);
            end
        end
        calm = 1'b0;
        settle();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Timeout
    initial begin
        #80_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
